### design/alidr_pkg.sv
// package: types, sizes and codes for the list unit
`default_nettype none
package alidr_pkg;
	localparam int CAPACITY = 8;
	localparam int MODE_W   = 3;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 3;
	localparam int AMT_W    = 8;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 4;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SPAN_W   = CNT_W;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int BIT_W    = $clog2(AMT_W);

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_DEL_FRONT = 3'd3,
		MODE_DEL_BACK  = 3'd4,
		MODE_DEL_POS   = 3'd5,
		MODE_ROTATE    = 3'd6,
		MODE_LIST      = 3'd7
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_INVALID = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_LEFT  = 2'd2,
		CMD_RIGHT = 2'd3
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_REM  = 3'd1,
		S_ROT  = 3'd2,
		S_DONE = 3'd3,
		S_LIST = 3'd4
	} state_t;
endpackage
`default_nettype wire

### design/alidr_if.sv
// interfaces: request and response channels of the list unit
`default_nettype none
interface alidr_req_if;
	logic                             valid;
	logic                             ready;
	logic [alidr_pkg::MODE_W-1:0]     mode;
	logic signed [alidr_pkg::DATA_W-1:0] value;
	logic [alidr_pkg::POS_W-1:0]      position;
	logic [alidr_pkg::AMT_W-1:0]      rotate_amount;

	modport source (output valid, mode, value, position, rotate_amount, input ready);
	modport sink (input valid, mode, value, position, rotate_amount, output ready);
endinterface

interface alidr_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [alidr_pkg::STAT_W-1:0]     status;
	logic signed [alidr_pkg::DATA_W-1:0] element;
	logic [alidr_pkg::COUNT_W-1:0]    count;
	logic                             last;

	modport source (output valid, status, element, count, last, input ready);
	modport sink (input valid, status, element, count, last, output ready);
endinterface
`default_nettype wire

### design/alidr_cell.sv
// one list cell: holds an entry, loads it or takes a neighbor's entry
`default_nettype none
module alidr_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire alidr_pkg::cell_cmd_t cmd,
	input  wire alidr_pkg::data_t     value,
	input  wire alidr_pkg::data_t     left,
	input  wire alidr_pkg::data_t     right,
	output alidr_pkg::data_t          entry
);
	alidr_pkg::data_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			case (cmd)
				alidr_pkg::CMD_LOAD:  entry_q <= value;
				alidr_pkg::CMD_LEFT:  entry_q <= left;
				alidr_pkg::CMD_RIGHT: entry_q <= right;
				default:              entry_q <= entry_q;
			endcase
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

### design/array_list_insert_delete_rotate_unit.sv
// top level: ordered list held in a chain of cells, with request sequencer
//
//  channel | dir | word fields
//  req     | in  | mode, value, position, rotate_amount
//  rsp     | out | status, element, count, last
//
// insert, delete and no-op rotate: accepted, answer registered and shown in the cycle after
// rotate: accept, remainder of amount by span, shift by k = amount mod span, then load the response
// list: one word per cycle per held entry, paced by rsp.ready
// reset clears all cells and the fill count; a full response register stalls req
`default_nettype none
module array_list_insert_delete_rotate_unit (
	input wire logic   clk,
	input wire logic   arst_n,
	alidr_req_if.sink  req,
	alidr_rsp_if.source rsp
);
	localparam int N = alidr_pkg::CAPACITY;

	alidr_pkg::state_t                state_q, state_d;
	logic [alidr_pkg::CNT_W-1:0]      fill_q, fill_d;
	logic [alidr_pkg::SPAN_W-1:0]     span_q, span_d;
	logic [alidr_pkg::SPAN_W:0]       rem_q, rem_d, rem_sh;
	logic [alidr_pkg::AMT_W-1:0]      amt_q, amt_d;
	logic [alidr_pkg::BIT_W-1:0]      bit_q, bit_d;
	logic [alidr_pkg::IDX_W-1:0]      idx_q, idx_d, rd_idx;

	logic                             out_valid_q;
	alidr_pkg::status_t               status_q, status_d;
	alidr_pkg::data_t                 element_q, element_d;
	logic [alidr_pkg::CNT_W-1:0]      count_q, count_d;
	logic                             last_q, last_d;
	logic                             load_out;
	logic                             out_free;

	alidr_pkg::cell_cmd_t             cmd [N];
	alidr_pkg::data_t                 entry [N];
	alidr_pkg::data_t                 left_in [N];
	alidr_pkg::data_t                 right_in [N];
	alidr_pkg::data_t                 rd_data;

	logic [alidr_pkg::CMP_W-1:0]      pos_w, fill_w, ins_at, del_at;
	logic                             full, empty, del_bad, rot_nop;

	// cell chain
	for (genvar g = 0; g < N; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign left_in[g] = rd_data;
		end else begin : g_body
			assign left_in[g] = entry[g-1];
		end
		if (g == N - 1) begin : g_tail
			assign right_in[g] = '0;
		end else begin : g_mid
			assign right_in[g] = entry[g+1];
		end
		alidr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[g]),
			.value  (req.value),
			.left   (left_in[g]),
			.right  (right_in[g]),
			.entry  (entry[g])
		);
	end

	// shared read port: wraparound source while rotating, listed entry while listing
	assign rd_idx  = (state_q == alidr_pkg::S_LIST) ? idx_q
		: alidr_pkg::IDX_W'(span_q - alidr_pkg::SPAN_W'(1));
	assign rd_data = entry[rd_idx];

	assign out_free = !out_valid_q || rsp.ready;
	assign pos_w    = alidr_pkg::CMP_W'(req.position);
	assign fill_w   = alidr_pkg::CMP_W'(fill_q);
	assign full     = (fill_q == alidr_pkg::CNT_W'(N));
	assign empty    = (fill_q == '0);
	assign rot_nop  = req.value[alidr_pkg::DATA_W-1] || (req.value == '0);
	assign rem_sh   = {rem_q[alidr_pkg::SPAN_W-1:0], amt_q[alidr_pkg::AMT_W-1]};

	always_comb begin
		case (req.mode)
			alidr_pkg::MODE_INS_FRONT: ins_at = '0;
			alidr_pkg::MODE_INS_BACK:  ins_at = fill_w;
			default:                   ins_at = (pos_w >= fill_w) ? fill_w : pos_w;
		endcase
		case (req.mode)
			alidr_pkg::MODE_DEL_FRONT: del_at = '0;
			alidr_pkg::MODE_DEL_BACK:  del_at = fill_w - alidr_pkg::CMP_W'(1);
			default:                   del_at = pos_w;
		endcase
		del_bad = (req.mode == alidr_pkg::MODE_DEL_POS) && (pos_w >= fill_w);
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		span_d    = span_q;
		rem_d     = rem_q;
		amt_d     = amt_q;
		bit_d     = bit_q;
		idx_d     = idx_q;
		load_out  = 1'b0;
		status_d  = alidr_pkg::STAT_OK;
		element_d = '0;
		count_d   = fill_q;
		last_d    = 1'b1;
		req.ready = 1'b0;
		for (int i = 0; i < N; i++) begin
			cmd[i] = alidr_pkg::CMD_HOLD;
		end

		unique case (state_q)
			alidr_pkg::S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					unique case (req.mode) inside
						alidr_pkg::MODE_INS_FRONT, alidr_pkg::MODE_INS_BACK,
						alidr_pkg::MODE_INS_POS: begin
							load_out = 1'b1;
							if (full) begin
								status_d = alidr_pkg::STAT_FULL;
							end else begin
								for (int i = 0; i < N; i++) begin
									if (alidr_pkg::CMP_W'(i) == ins_at) begin
										cmd[i] = alidr_pkg::CMD_LOAD;
									end else if (alidr_pkg::CMP_W'(i) > ins_at
										&& alidr_pkg::CMP_W'(i) <= fill_w) begin
										cmd[i] = alidr_pkg::CMD_LEFT;
									end
								end
								fill_d  = fill_q + alidr_pkg::CNT_W'(1);
								count_d = fill_d;
							end
						end
						alidr_pkg::MODE_DEL_FRONT, alidr_pkg::MODE_DEL_BACK,
						alidr_pkg::MODE_DEL_POS: begin
							load_out = 1'b1;
							if (empty) begin
								status_d = alidr_pkg::STAT_EMPTY;
							end else if (del_bad) begin
								status_d = alidr_pkg::STAT_INVALID;
							end else begin
								for (int i = 0; i < N; i++) begin
									if (alidr_pkg::CMP_W'(i) >= del_at
										&& alidr_pkg::CMP_W'(i) + alidr_pkg::CMP_W'(1) < fill_w) begin
										cmd[i] = alidr_pkg::CMD_RIGHT;
									end
								end
								fill_d  = fill_q - alidr_pkg::CNT_W'(1);
								count_d = fill_d;
							end
						end
						alidr_pkg::MODE_ROTATE: begin
							if (rot_nop) begin
								load_out = 1'b1;
							end else begin
								span_d  = ($unsigned(req.value) > alidr_pkg::DATA_W'(N))
									? alidr_pkg::SPAN_W'(N)
									: req.value[alidr_pkg::SPAN_W-1:0];
								amt_d   = req.rotate_amount;
								rem_d   = '0;
								bit_d   = '0;
								state_d = alidr_pkg::S_REM;
							end
						end
						alidr_pkg::MODE_LIST: begin
							if (empty) begin
								load_out = 1'b1;
								status_d = alidr_pkg::STAT_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = alidr_pkg::S_LIST;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			alidr_pkg::S_REM: begin
				// restoring remainder, one amount bit per cycle, msb first
				rem_d = (rem_sh >= {1'b0, span_q}) ? rem_sh - {1'b0, span_q} : rem_sh;
				amt_d = amt_q << 1;
				bit_d = bit_q + alidr_pkg::BIT_W'(1);
				if (bit_q == alidr_pkg::BIT_W'(alidr_pkg::AMT_W - 1)) begin
					state_d = alidr_pkg::S_ROT;
				end
			end
			alidr_pkg::S_ROT: begin
				if (rem_q == '0) begin
					state_d = alidr_pkg::S_DONE;
				end else begin
					for (int i = 0; i < N; i++) begin
						if (alidr_pkg::SPAN_W'(i) < span_q) begin
							cmd[i] = alidr_pkg::CMD_LEFT;
						end
					end
					rem_d = rem_q - (alidr_pkg::SPAN_W + 1)'(1);
				end
			end
			alidr_pkg::S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = alidr_pkg::S_IDLE;
				end
			end
			alidr_pkg::S_LIST: begin
				if (out_free) begin
					load_out  = 1'b1;
					element_d = rd_data;
					last_d    = (alidr_pkg::CNT_W'(idx_q) + alidr_pkg::CNT_W'(1) == fill_q);
					idx_d     = idx_q + alidr_pkg::IDX_W'(1);
					if (last_d) begin
						state_d = alidr_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = alidr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= alidr_pkg::S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			span_q      <= '0;
			rem_q       <= '0;
			amt_q       <= '0;
			bit_q       <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			span_q  <= span_d;
			rem_q   <= rem_d;
			amt_q   <= amt_d;
			bit_q   <= bit_d;
			idx_q   <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q  <= status_d;
			element_q <= element_d;
			count_q   <= count_d;
			last_q    <= last_d;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = status_q;
	assign rsp.element = element_q;
	assign rsp.count   = alidr_pkg::COUNT_W'(count_q);
	assign rsp.last    = last_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= alidr_pkg::CNT_W'(N))
		else $error("fill count above capacity");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == alidr_pkg::S_IDLE)
		else $error("request taken while busy");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.mode != alidr_pkg::MODE_ROTATE
			&& req.mode != alidr_pkg::MODE_LIST) |=> (rsp.valid && rsp.last))
		else $error("single-word request not answered next cycle");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.count == alidr_pkg::COUNT_W'(fill_q))
		else $error("reported count differs from fill count");
`endif
endmodule
`default_nettype wire
